// File: sv/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared constants, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath of the stack.
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 5;

    // Input transfer: operation, key, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    // Result transfer: status, popped_key, removed_count, occupancy, padded.
    localparam int M_TDATA_W = 48;
    localparam int M_USED_W  = ST_W + KEY_W + CNT_OUT_W + CNT_OUT_W;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_PURGE = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic            load_in;     // capture the accepted input transfer
        logic            push;        // write key on top, count up
        logic            pop_read;    // count down, read the old top
        logic            pop_take;    // capture the read top as popped key
        logic            scan_start;  // clear purge read and write pointers
        logic            scan_read;   // read the entry at the purge read pointer
        logic            scan_finish; // commit the compacted count
        logic            set_status;  // load the result status code
        logic [ST_W-1:0] status;
        logic            load_out;    // move the result into the output register
    } lsp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            scan_done;
        logic            out_free;
    } lsp_sts_t;

endpackage

// File: sv/lsp_ram.sv
// ----------------------------------------------------------------------------
// lsp_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module lsp_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/lsp_datapath.sv
// ----------------------------------------------------------------------------
// lsp_datapath
// Key store, entry count, purge pointers and result registers. Carries out
// the commands of the controller and reports the conditions it branches on.
// ----------------------------------------------------------------------------
module lsp_datapath #(
    parameter int DEPTH = lsp_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lsp_pkg::S_TDATA_W-1:0] s_tdata,
    input  lsp_pkg::lsp_cmd_t             cmd,
    output lsp_pkg::lsp_sts_t             sts,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsp_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PAD_W  = lsp_pkg::M_TDATA_W - lsp_pkg::M_USED_W;

    logic [lsp_pkg::OP_W-1:0]      op_reg;
    logic signed [lsp_pkg::KEY_W-1:0] key_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              rd_reg;
    logic [CNT_W-1:0]              wr_reg;
    logic                          pend_reg;
    logic [lsp_pkg::ST_W-1:0]      res_status_reg;
    logic [lsp_pkg::KEY_W-1:0]     res_popped_reg;
    logic [lsp_pkg::CNT_OUT_W-1:0] res_removed_reg;
    logic                          m_tvalid_reg;
    logic [lsp_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [CNT_W-1:0]              pop_idx;
    logic [CNT_W-1:0]              purged;
    logic [ADDR_W-1:0]             raddr;
    logic [ADDR_W-1:0]             waddr;
    logic [lsp_pkg::KEY_W-1:0]     wdata;
    logic [lsp_pkg::KEY_W-1:0]     rd_data;
    logic                          keep;
    logic                          we;
    logic [lsp_pkg::CNT_OUT_W-1:0] occ_out;

    assign pop_idx = count_reg - CNT_W'(1);
    assign purged  = count_reg - wr_reg;
    assign raddr   = cmd.pop_read ? pop_idx[ADDR_W-1:0] : rd_reg[ADDR_W-1:0];

    // An entry read during a purge in the previous cycle is kept when it differs
    // from the key; it moves down to the write pointer, which never passes
    // the read pointer.
    assign keep  = pend_reg && (rd_data != key_reg);
    assign we    = cmd.push || keep;
    assign waddr = cmd.push ? count_reg[ADDR_W-1:0] : wr_reg[ADDR_W-1:0];
    assign wdata = cmd.push ? key_reg : rd_data;

    assign occ_out = lsp_pkg::CNT_OUT_W'(count_reg);

    lsp_ram #(
        .WIDTH (lsp_pkg::KEY_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_store (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.scan_read;
            if (cmd.push) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.pop_read) begin
                count_reg <= pop_idx;
            end else if (cmd.scan_finish) begin
                count_reg <= wr_reg;
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg          <= s_tdata[lsp_pkg::OP_W-1:0];
            key_reg         <= s_tdata[lsp_pkg::OP_W +: lsp_pkg::KEY_W];
            res_status_reg  <= lsp_pkg::ST_DONE;
            res_popped_reg  <= '0;
            res_removed_reg <= '0;
        end
        if (cmd.set_status) begin
            res_status_reg <= cmd.status;
        end
        if (cmd.pop_take) begin
            res_popped_reg <= rd_data;
        end
        if (cmd.scan_start) begin
            rd_reg <= '0;
            wr_reg <= '0;
        end
        if (cmd.scan_read) begin
            rd_reg <= rd_reg + CNT_W'(1);
        end
        if (keep) begin
            wr_reg <= wr_reg + CNT_W'(1);
        end
        if (cmd.scan_finish) begin
            res_removed_reg <= lsp_pkg::CNT_OUT_W'(purged);
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, occ_out, res_removed_reg,
                            res_popped_reg, res_status_reg};
        end
    end

    assign sts.op        = op_reg;
    assign sts.full      = (count_reg == CNT_W'(DEPTH));
    assign sts.empty     = (count_reg == '0);
    assign sts.scan_done = (rd_reg == count_reg);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: sv/lsp_ctrl.sv
// ----------------------------------------------------------------------------
// lsp_ctrl
// Controller of the stack: takes one transfer at a time, sequences push,
// pop and the purge scan over the datapath, and hands the result on.
// ----------------------------------------------------------------------------
module lsp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lsp_pkg::lsp_sts_t sts,
    output lsp_pkg::lsp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP_TAKE,
        S_SCAN,
        S_SCAN_END,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        cmd.status = lsp_pkg::ST_DONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_RESP;
                unique case (sts.op)
                    lsp_pkg::OP_PUSH: begin
                        if (sts.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = lsp_pkg::ST_FULL;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end
                    lsp_pkg::OP_POP: begin
                        if (sts.empty) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = lsp_pkg::ST_EMPTY;
                        end else begin
                            cmd.pop_read = 1'b1;
                            state_next   = S_POP_TAKE;
                        end
                    end
                    lsp_pkg::OP_PURGE: begin
                        if (sts.empty) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = lsp_pkg::ST_EMPTY;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    default: begin
                        // The unused operation code leaves the store alone.
                    end
                endcase
            end
            S_POP_TAKE: begin
                cmd.pop_take = 1'b1;
                state_next   = S_RESP;
            end
            S_SCAN: begin
                // The last entry read is compared and written in the cycle
                // that sees the read pointer reach the count.
                if (sts.scan_done) begin
                    state_next = S_SCAN_END;
                end else begin
                    cmd.scan_read = 1'b1;
                end
            end
            S_SCAN_END: begin
                cmd.scan_finish = 1'b1;
                state_next      = S_RESP;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// File: sv/lifo_stack_with_key_purge.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_key_purge
// Bounded last-in-first-out store of signed 32-bit keys with push, pop and
// a purge that removes every entry equal to a key.
// ----------------------------------------------------------------------------
// The block works on one transfer at a time. After acceptance, push and the
// short cases (full, empty, unused code) go from decode to the result state;
// pop adds a step that takes the read top, and purge adds a scan and a scan
// end step, the scan walking the key store through its single read port one
// entry per cycle while writing kept entries down in order. A new input
// transfer is taken as soon as the previous result sits in the output
// register, even if it has not been taken yet. The key store has no reset;
// the entry count is cleared, and only entries below it are ever read.
// ----------------------------------------------------------------------------
module lifo_stack_with_key_purge #(
    parameter int DEPTH = lsp_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] operation, [33:2] key, [39:34] zero
    input  logic [lsp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [33:2] popped_key, [38:34] removed_count,
    // [43:39] occupancy, [47:44] zero
    output logic [lsp_pkg::M_TDATA_W-1:0] m_tdata
);

    lsp_pkg::lsp_cmd_t cmd;
    lsp_pkg::lsp_sts_t sts;

    lsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lsp_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

`ifndef SYNTHESIS
    // A push is never issued into a full store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !sts.full)
        else $error("push issued while store full");

    // A result never overwrites one that is still waiting to be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // Only one item is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer accepted while busy");

    // A purge scan is only started on a store that holds entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_start |-> !sts.empty)
        else $error("purge scan started on empty store");
`endif

endmodule

// File: verif/tb_lifo_stack_with_key_purge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_key_purge
// Self-checking bench for the key stack with purge. A queue of operations
// is filled with a directed opening and then random episodes: mixed traffic
// on a small key pool, fills past full, drains past empty, and purges that
// clear a full store. A clocked driver sends the operations in bursts with
// gaps. A clocked monitor checks every result field by field against a
// stack model kept in the bench. The receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_key_purge;
    import lsp_pkg::*;

    localparam int                STACK_DEPTH = DEPTH_DEFAULT;
    localparam int                ITEM_TARGET = 1950;
    localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [KEY_W-1:0]     popped_key;
        logic [CNT_OUT_W-1:0] removed_count;
        logic [CNT_OUT_W-1:0] occupancy;
    } stack_result_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic             wait_idle;  // hold off until every result is back
    } stack_op_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    stack_op_t     pending_q[$];
    stack_result_t expected_q[$];

    // Bench copy of the stack: entry 0 is the bottom.
    logic [KEY_W-1:0] model_keys[STACK_DEPTH];
    int               model_count = 0;

    logic [KEY_W-1:0] key_pool[4];
    int               fail_count  = 0;
    int               items_sent  = 0;
    int               items_built = 0;
    logic             s_took      = 1'b0;
    logic             hold_active = 1'b0;

    lifo_stack_with_key_purge #(
        .DEPTH(STACK_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic stack_result_t predict_stack(input logic [OP_W-1:0] op,
                                                    input logic [KEY_W-1:0] key);
        stack_result_t res;
        int            wr;
        res = '0;
        res.status = ST_DONE;
        case (op)
            OP_PUSH: begin
                if (model_count >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    model_keys[model_count] = key;
                    model_count++;
                end
            end
            OP_POP: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    model_count--;
                    res.popped_key = model_keys[model_count];
                end
            end
            OP_PURGE: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    wr = 0;
                    for (int rd = 0; rd < model_count; rd++) begin
                        if (model_keys[rd] != key) begin
                            model_keys[wr] = model_keys[rd];
                            wr++;
                        end
                    end
                    res.removed_count = CNT_OUT_W'(model_count - wr);
                    model_count = wr;
                end
            end
            default: begin
            end
        endcase
        res.occupancy = CNT_OUT_W'(model_count);
        return res;
    endfunction

    task automatic add_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                          input logic wait_idle = 1'b0);
        stack_op_t item;
        item.op        = op;
        item.key       = key;
        item.wait_idle = wait_idle;
        pending_q.push_back(item);
        items_built++;
    endtask

    // Mostly keys from a small pool, so that purges find matches.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 7) begin
            return key_pool[$urandom_range(0, 3)];
        end
        return $urandom;
    endfunction

    task automatic refresh_pool();
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 5))
                0:       key_pool[i] = 32'h8000_0000;
                1:       key_pool[i] = 32'h7FFF_FFFF;
                2:       key_pool[i] = 32'hFFFF_FFFF;
                3:       key_pool[i] = 32'h0000_0000;
                default: key_pool[i] = $urandom;
            endcase
        end
    endtask

    task automatic build_directed();
        add_op(OP_POP,    32'h0000_0000);
        add_op(OP_PURGE,  32'h0000_0000);
        add_op(OP_UNUSED, 32'hFFFF_FFFF);
        add_op(OP_PUSH,   32'h7FFF_FFFF);
        add_op(OP_PUSH,   32'h8000_0000);
        add_op(OP_PUSH,   32'h0000_0000);
        add_op(OP_PUSH,   32'hFFFF_FFFF);
        add_op(OP_PUSH,   32'h8000_0000);
        add_op(OP_UNUSED, 32'h5555_AAAA);
        // Two matches, one of them in the middle: the order must survive.
        add_op(OP_PURGE,  32'h8000_0000);
        add_op(OP_PURGE,  32'h1234_5678);
        add_op(OP_POP,    32'hFFFF_FFFF);
        add_op(OP_POP,    32'h0000_0000);
        add_op(OP_PUSH,   32'hA5A5_5A5A);
        // The top entry itself matches.
        add_op(OP_PURGE,  32'hA5A5_5A5A);
        add_op(OP_POP,    32'h0000_0000);
        add_op(OP_POP,    32'h0000_0000);
        add_op(OP_POP,    32'h0000_0000);
        add_op(OP_PURGE,  32'h7FFF_FFFF, 1'b1);
    endtask

    task automatic build_random();
        int          kind;
        int          len;
        int          pick;
        logic [KEY_W-1:0] k;
        logic [OP_W-1:0]  op;
        while (items_built < ITEM_TARGET) begin
            refresh_pool();
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                // Mixed traffic, push heavy so the store spends time near full.
                len = $urandom_range(10, 40);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45)      op = OP_PUSH;
                    else if (pick < 75) op = OP_POP;
                    else if (pick < 95) op = OP_PURGE;
                    else                op = OP_UNUSED;
                    add_op(op, pick_key(), (i == 0) && ($urandom_range(0, 7) == 0));
                end
            end else if (kind == 5) begin
                // Fill past full so some pushes are refused.
                for (int i = 0; i < STACK_DEPTH + 2; i++) begin
                    add_op(OP_PUSH, pick_key());
                end
                add_op(OP_UNUSED, $urandom);
            end else if (kind == 6) begin
                // Drain past empty.
                for (int i = 0; i < STACK_DEPTH + 2; i++) begin
                    add_op(OP_POP, $urandom);
                end
                add_op(OP_PURGE, pick_key());
            end else if (kind == 7) begin
                // Empty the store, fill it with one key, purge it all at once.
                k = pick_key();
                for (int i = 0; i < STACK_DEPTH + 1; i++) begin
                    add_op(OP_POP, $urandom);
                end
                for (int i = 0; i < STACK_DEPTH; i++) begin
                    add_op(OP_PUSH, k);
                end
                add_op(OP_PURGE, k);
                add_op(OP_POP, $urandom);
            end else begin
                // Full store with interleaved keys, purge one, pop the rest.
                k = key_pool[0];
                for (int i = 0; i < STACK_DEPTH + 1; i++) begin
                    add_op(OP_POP, $urandom);
                end
                for (int i = 0; i < STACK_DEPTH; i++) begin
                    add_op(OP_PUSH, ($urandom_range(0, 1) == 0) ? k : $urandom);
                end
                add_op(OP_PURGE, k, $urandom_range(0, 3) == 0);
                len = $urandom_range(4, STACK_DEPTH + 1);
                for (int i = 0; i < len; i++) begin
                    add_op(OP_POP, $urandom);
                end
            end
        end
    endtask

    // Input side: record the transfer and predict its result.
    always @(posedge aclk) begin
        s_took <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_q.push_back(predict_stack(s_tdata[OP_W-1:0],
                                               s_tdata[OP_W +: KEY_W]));
            items_sent++;
        end
    end

    // Driver: bursts of transfers separated by random gaps.
    int        burst_left = 0;
    int        gap_left   = 0;
    always @(negedge aclk) begin
        stack_op_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_took) begin
            // Offer stays up until it is taken.
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (pending_q.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (pending_q[0].wait_idle && expected_q.size() != 0) begin
            s_tvalid <= 1'b0;
        end else begin
            item = pending_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {{(S_TDATA_W - OP_W - KEY_W){1'b0}}, item.key, item.op};
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 20);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
    end

    // Receiver: a stall pattern that is picked anew at random, now and again.
    int rx_cycle = 0;
    int rx_mode  = 0;
    always @(negedge aclk) begin
        logic ready;
        rx_cycle++;
        if (rx_cycle % 64 == 0) begin
            rx_mode = $urandom_range(0, 4);
        end
        case (rx_mode)
            0:       ready = 1'b1;
            1:       ready = (rx_cycle % 4) != 0;
            2:       ready = 1'($urandom_range(0, 1));
            3:       ready = (rx_cycle % 5) == 0;
            default: ready = (rx_cycle % 16) < 8;
        endcase
        m_tready <= aresetn && !hold_active && ready;
    end

    // Long receiver hold-offs while the sender keeps offering.
    initial begin
        wait (items_sent >= 300);
        @(posedge aclk);
        hold_active = 1'b1;
        repeat (250) @(posedge aclk);
        hold_active = 1'b0;
        wait (items_sent >= 1300);
        @(posedge aclk);
        hold_active = 1'b1;
        repeat (250) @(posedge aclk);
        hold_active = 1'b0;
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge aclk) begin
        stack_result_t want;
        stack_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status        = m_tdata[ST_W-1:0];
            got.popped_key    = m_tdata[ST_W +: KEY_W];
            got.removed_count = m_tdata[ST_W + KEY_W +: CNT_OUT_W];
            got.occupancy     = m_tdata[ST_W + KEY_W + CNT_OUT_W +: CNT_OUT_W];
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%t: result transfer with nothing pending: %h", $realtime,
                             m_tdata);
                end
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%t: mismatch status %0d/%0d popped_key %h/%h",
                                 $realtime, want.status, got.status,
                                 want.popped_key, got.popped_key);
                        $display("    removed_count %0d/%0d occupancy %0d/%0d",
                                 want.removed_count, got.removed_count,
                                 want.occupancy, got.occupancy);
                    end
                end
            end
        end
    end

    initial begin
        build_directed();
        build_random();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        while (pending_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (expected_q.size() != 0) begin
            fail_count++;
            $display("%0d results never arrived", expected_q.size());
        end
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
